// ===== sv/lsa_pkg.sv =====
// ----------------------------------------------------------------------------
// lsa_pkg: shared types for the linked slab allocator
// Request and result beat layouts and field widths used by every module but lsa_ram.
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int SIZE_W = 11;
    localparam int PID_W  = 6;
    localparam int RND_W  = 12;

    typedef struct packed {
        logic              kind;
        logic [PID_W-1:0]  pid;
        logic [SIZE_W-1:0] request_size;
    } t_lsa_req;

    typedef struct packed {
        logic              status;
        logic [SIZE_W-1:0] first_slab;
    } t_lsa_rsp;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_OOM     = 1'b1;

endpackage

// ===== sv/lsa_ram.sv =====
// ----------------------------------------------------------------------------
// lsa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lsa_round_unit.sv =====
// ----------------------------------------------------------------------------
// lsa_round_unit: rounds a slab count up to a multiple of the block size
// Accumulates the block size one step per cycle until the count is covered.
// ----------------------------------------------------------------------------
module lsa_round_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lsa_pkg::SIZE_W-1:0] i_want,
    input  logic [lsa_pkg::SIZE_W-1:0] i_bs,
    output logic                       o_done,
    output logic [lsa_pkg::RND_W-1:0]  o_count
);

    logic                       r_busy, n_busy;
    logic [lsa_pkg::RND_W-1:0]  r_acc, n_acc;
    logic [lsa_pkg::SIZE_W-1:0] r_want, n_want;
    logic [lsa_pkg::SIZE_W-1:0] bs_eff;
    logic                       covered;

    // A zero block size behaves as one.
    assign bs_eff  = (i_bs == '0) ? lsa_pkg::SIZE_W'(1) : i_bs;
    assign covered = r_acc >= lsa_pkg::RND_W'(r_want);

    always_comb begin
        n_busy = r_busy;
        n_acc  = r_acc;
        n_want = r_want;
        if (i_start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_want = i_want;
        end else if (r_busy) begin
            if (covered) begin
                n_busy = 1'b0;
            end else begin
                n_acc = r_acc + lsa_pkg::RND_W'(bs_eff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_want <= n_want;
    end

    assign o_done  = r_busy && covered && !i_start;
    assign o_count = r_acc;

endmodule

// ===== sv/linked_slab_allocator_core.sv =====
// ----------------------------------------------------------------------------
// linked_slab_allocator_core: slab allocator with a sorted free list
// Each beat walks its lists through the link RAM, an address state then a
//   data state per list step; a reserve refill adds rounding and a slab fill.
// Throughput: one beat at a time; the next-link RAM's single read port sets
//   the pace, so the time per beat follows the lengths of the lists walked.
// Reset (synchronous, active low): free list and all chains empty, reserve
//   pointer zero, block size one; the link RAM is not cleared.
// ----------------------------------------------------------------------------
module linked_slab_allocator_core #(
    parameter int POOL_SLABS = 1024,
    parameter int MAX_PROCS  = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  lsa_pkg::t_lsa_req          i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output lsa_pkg::t_lsa_rsp          o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_we,
    input  logic [lsa_pkg::SIZE_W-1:0] i_cfg_wdata
);

    // Address width of the link RAM, and link width that can also hold null.
    localparam int AW  = $clog2(POOL_SLABS);
    localparam int LW  = AW + 1;
    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int SW  = LW + lsa_pkg::RND_W + 1;
    localparam logic [LW-1:0] NIL = LW'(POOL_SLABS);

    // The sequencer is one-hot. Every list step is an address state followed
    // by a data state, since the link RAM returns registered data.
    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_MOD   = 21'h000002,
        S_RND   = 21'h000004,
        S_FILL  = 21'h000008,
        S_LINK  = 21'h000010,
        S_WRD   = 21'h000020,
        S_WDT   = 21'h000040,
        S_CUT   = 21'h000080,
        S_AHD   = 21'h000100,
        S_ARD   = 21'h000200,
        S_ADT   = 21'h000400,
        S_CHRD  = 21'h000800,
        S_CHDT  = 21'h001000,
        S_FCHK  = 21'h002000,
        S_FNX   = 21'h004000,
        S_IRD   = 21'h008000,
        S_IDT   = 21'h010000,
        S_IW2   = 21'h020000,
        S_FIN   = 21'h040000,
        S_SPR1  = 21'h080000,
        S_SPR2  = 21'h100000
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_kind, n_kind;
    logic [lsa_pkg::PID_W-1:0]  r_pm, n_pm;
    logic [lsa_pkg::SIZE_W-1:0] r_rem, n_rem;
    logic [lsa_pkg::SIZE_W-1:0] r_bs, n_bs;
    logic [LW-1:0]              r_fh, n_fh;
    logic [LW-1:0]              r_rp, n_rp;
    logic [LW-1:0]              r_end, n_end;
    logic [LW-1:0]              r_cur, n_cur;
    logic [LW-1:0]              r_nxt, n_nxt;
    logic [LW-1:0]              r_c, n_c;
    logic [LW-1:0]              r_n, n_n;
    logic [LW-1:0]              r_first, n_first;
    logic [LW-1:0]              r_wa, n_wa;
    logic [LW-1:0]              r_last, n_last;
    logic [LW-1:0]              r_start, n_start;
    logic                       r_second, n_second;
    logic [MAX_PROCS-1:0]       r_chv, n_chv;
    logic                       r_res_st, n_res_st;
    logic [LW-1:0]              r_res_first, n_res_first;
    logic                       r_out_valid, n_out_valid;
    lsa_pkg::t_lsa_rsp          r_out, n_out;

    logic                       lk_we;
    logic [AW-1:0]              lk_waddr, lk_raddr;
    logic [LW-1:0]              lk_wdata, lk_rdata, lk_val;
    logic                       ch_we;
    logic [PW-1:0]              ch_addr;
    logic [LW-1:0]              ch_rdata, ch_head;
    logic                       rnd_start, rnd_done;
    logic [lsa_pkg::SIZE_W-1:0] rnd_want;
    logic [lsa_pkg::RND_W-1:0]  rnd_count;
    logic                       fits;

    assign ch_addr = PW'(r_pm);
    // Links beyond the pool read as null.
    assign lk_val  = (lk_rdata >= NIL) ? NIL : lk_rdata;
    assign ch_head = r_chv[ch_addr] ? ch_rdata : NIL;
    assign fits    = (SW'(r_rp) + SW'(rnd_count)) <= SW'(POOL_SLABS);

    lsa_ram #(.WIDTH(LW), .DEPTH(POOL_SLABS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    lsa_ram #(.WIDTH(LW), .DEPTH(MAX_PROCS)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (ch_addr),
        .i_wdata (r_first),
        .i_raddr (ch_addr),
        .o_rdata (ch_rdata)
    );

    lsa_round_unit u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rnd_start),
        .i_want  (rnd_want),
        .i_bs    (r_bs),
        .o_done  (rnd_done),
        .o_count (rnd_count)
    );

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_pm        = r_pm;
        n_rem       = r_rem;
        n_bs        = r_bs;
        n_fh        = r_fh;
        n_rp        = r_rp;
        n_end       = r_end;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_c         = r_c;
        n_n         = r_n;
        n_first     = r_first;
        n_wa        = r_wa;
        n_last      = r_last;
        n_start     = r_start;
        n_second    = r_second;
        n_chv       = r_chv;
        n_res_st    = r_res_st;
        n_res_first = r_res_first;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        lk_we       = 1'b0;
        lk_waddr    = AW'(r_end);
        lk_wdata    = NIL;
        lk_raddr    = AW'(r_end);
        ch_we       = 1'b0;
        rnd_start   = 1'b0;
        rnd_want    = r_rem;

        // The result register drains independently of the sequencer.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_bs = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = i_in_data.kind;
                    n_pm     = i_in_data.pid;
                    n_rem    = i_in_data.request_size;
                    n_second = 1'b0;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                // Fold the pid into range by repeated subtraction.
                if (32'(r_pm) >= MAX_PROCS) begin
                    n_pm = r_pm - lsa_pkg::PID_W'(MAX_PROCS);
                end else if (r_kind == lsa_pkg::KIND_FREE) begin
                    n_state = S_CHRD;
                end else if (r_rem == '0) begin
                    n_res_st    = lsa_pkg::ST_OK;
                    n_res_first = NIL;
                    n_state     = S_FIN;
                end else if (r_fh == NIL) begin
                    rnd_start = 1'b1;
                    n_state   = S_RND;
                end else begin
                    n_end   = r_fh;
                    n_state = S_WRD;
                end
            end
            S_RND: begin
                if (rnd_done) begin
                    if (!fits) begin
                        n_res_st    = lsa_pkg::ST_OOM;
                        n_res_first = NIL;
                        n_state     = S_FIN;
                    end else begin
                        n_start = r_rp;
                        n_wa    = r_rp;
                        n_last  = r_rp + LW'(rnd_count) - LW'(1);
                        n_rp    = r_rp + LW'(rnd_count);
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                // Thread the fresh block into a linked run, one slab a cycle.
                lk_we    = 1'b1;
                lk_waddr = AW'(r_wa);
                lk_wdata = (r_wa == r_last) ? NIL : r_wa + LW'(1);
                n_wa     = r_wa + LW'(1);
                if (r_wa == r_last) begin
                    if (r_second) begin
                        n_state = S_LINK;
                    end else begin
                        n_fh    = r_start;
                        n_end   = r_start;
                        n_state = S_WRD;
                    end
                end
            end
            S_LINK: begin
                lk_we    = 1'b1;
                lk_waddr = AW'(r_end);
                lk_wdata = r_start;
                n_state  = S_WRD;
            end
            S_WRD: begin
                lk_raddr = AW'(r_end);
                n_state  = S_WDT;
            end
            S_WDT: begin
                if (lk_val != NIL && r_rem > lsa_pkg::SIZE_W'(1)) begin
                    n_end   = lk_val;
                    n_rem   = r_rem - lsa_pkg::SIZE_W'(1);
                    n_state = S_WRD;
                end else if (r_rem > lsa_pkg::SIZE_W'(1)) begin
                    n_second  = 1'b1;
                    rnd_start = 1'b1;
                    n_state   = S_RND;
                end else begin
                    n_first = r_fh;
                    n_fh    = lk_val;
                    n_state = S_CUT;
                end
            end
            S_CUT: begin
                // Terminate the taken run; the chain head read starts now.
                lk_we    = 1'b1;
                lk_waddr = AW'(r_end);
                lk_wdata = NIL;
                n_state  = S_AHD;
            end
            S_AHD: begin
                if (ch_head == NIL) begin
                    ch_we          = 1'b1;
                    n_chv[ch_addr] = 1'b1;
                    n_res_st       = lsa_pkg::ST_OK;
                    n_res_first    = r_first;
                    n_state        = S_FIN;
                end else begin
                    n_cur   = ch_head;
                    n_state = S_ARD;
                end
            end
            S_ARD: begin
                lk_raddr = AW'(r_cur);
                n_state  = S_ADT;
            end
            S_ADT: begin
                if (lk_val != NIL) begin
                    n_cur   = lk_val;
                    n_state = S_ARD;
                end else begin
                    lk_we       = 1'b1;
                    lk_waddr    = AW'(r_cur);
                    lk_wdata    = r_first;
                    n_res_st    = lsa_pkg::ST_OK;
                    n_res_first = r_first;
                    n_state     = S_FIN;
                end
            end
            S_CHRD: begin
                n_state = S_CHDT;
            end
            S_CHDT: begin
                n_cur   = ch_head;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                lk_raddr = AW'(r_cur);
                if (r_cur == NIL) begin
                    n_chv[ch_addr] = 1'b0;
                    n_res_st       = lsa_pkg::ST_OK;
                    n_res_first    = NIL;
                    n_state        = S_FIN;
                end else begin
                    n_state = S_FNX;
                end
            end
            S_FNX: begin
                // The successor is saved before the slab is relinked.
                n_nxt = lk_val;
                if (r_fh == NIL || r_cur < r_fh) begin
                    lk_we    = 1'b1;
                    lk_waddr = AW'(r_cur);
                    lk_wdata = r_fh;
                    n_fh     = r_cur;
                    n_cur    = lk_val;
                    n_state  = S_FCHK;
                end else if (r_cur == r_fh) begin
                    n_cur   = lk_val;
                    n_state = S_FCHK;
                end else begin
                    n_c     = r_fh;
                    n_state = S_IRD;
                end
            end
            S_IRD: begin
                lk_raddr = AW'(r_c);
                n_state  = S_IDT;
            end
            S_IDT: begin
                if (lk_val == r_cur) begin
                    n_cur   = r_nxt;
                    n_state = S_FCHK;
                end else if (lk_val == NIL || lk_val > r_cur) begin
                    lk_we    = 1'b1;
                    lk_waddr = AW'(r_c);
                    lk_wdata = r_cur;
                    n_n      = lk_val;
                    n_state  = S_IW2;
                end else begin
                    n_c     = lk_val;
                    n_state = S_IRD;
                end
            end
            S_IW2: begin
                lk_we    = 1'b1;
                lk_waddr = AW'(r_cur);
                lk_wdata = r_n;
                n_cur    = r_nxt;
                n_state  = S_FCHK;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_res_st;
                    n_out.first_slab = lsa_pkg::SIZE_W'(r_res_first);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bs        <= lsa_pkg::SIZE_W'(1);
            r_fh        <= NIL;
            r_rp        <= '0;
            r_chv       <= '0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bs        <= n_bs;
            r_fh        <= n_fh;
            r_rp        <= n_rp;
            r_chv       <= n_chv;
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_pm        <= n_pm;
        r_rem       <= n_rem;
        r_end       <= n_end;
        r_cur       <= n_cur;
        r_nxt       <= n_nxt;
        r_c         <= n_c;
        r_n         <= n_n;
        r_first     <= n_first;
        r_wa        <= n_wa;
        r_last      <= n_last;
        r_start     <= n_start;
        r_res_st    <= n_res_st;
        r_res_first <= n_res_first;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/linked_slab_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// linked_slab_allocator_core_tb: self-checking bench for the slab allocator
// Drives a table of directed requests, then random allocate and free traffic
// under several block sizes. Every result beat is checked against a typed-in
// result or a local model of the free list, process chains and reserve pointer.
// ----------------------------------------------------------------------------
module linked_slab_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POOL   = 1024;
    localparam int unsigned PROCS  = 64;
    localparam int unsigned NIL    = POOL;
    localparam int unsigned IDLE_LIMIT = 8000000;
    localparam int unsigned HOLD_CYCLES = 400;

    // One row of the directed table. A row may first retune the block size;
    // a typed-in result is used only where it is obvious from the rules.
    typedef struct {
        bit                 cfg_en;
        int                 cfg_val;
        lsa_pkg::t_lsa_req  req;
        bit                 typed;
        lsa_pkg::t_lsa_rsp  rsp;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       in_valid;
    lsa_pkg::t_lsa_req          in_data;
    logic                       in_stall;
    logic                       out_valid;
    lsa_pkg::t_lsa_rsp          out_data;
    logic                       out_stall;
    logic                       cfg_we;
    logic [lsa_pkg::SIZE_W-1:0] cfg_wdata;

    // Allocator image kept by the bench.
    int unsigned link_mem [POOL];
    int unsigned chain_hd [PROCS];
    int unsigned free_hd;
    int unsigned rsv_ptr;
    int unsigned blk_size;

    lsa_pkg::t_lsa_rsp pending_rsp [$];
    int unsigned       fail_cnt;
    int unsigned       idle_cycles;
    int unsigned       rsp_seen;
    bit                hold_req;
    t_row              rows [$];

    linked_slab_allocator_core #(
        .POOL_SLABS (1024),
        .MAX_PROCS  (64)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 12 ns clock.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator model
    // ------------------------------------------------------------------

    // Links that point outside the pool read back as the null slab.
    function automatic int unsigned link_at(int unsigned s);
        if (s >= POOL) return NIL;
        return (link_mem[s] < POOL) ? link_mem[s] : NIL;
    endfunction

    function automatic void link_set(int unsigned s, int unsigned v);
        if (s < POOL) link_mem[s] = v;
    endfunction

    // Round a request up to whole blocks; a block size of zero acts as one.
    function automatic int unsigned round_to_blocks(int unsigned want);
        int unsigned bs;
        bs = (blk_size != 0) ? blk_size : 1;
        return ((want + bs - 1) / bs) * bs;
    endfunction

    // Carve count linked slabs off the bump pointer, or null if they do not fit.
    function automatic int unsigned carve_reserve(int unsigned count);
        int unsigned start;
        if (count == 0 || rsv_ptr > POOL || count > POOL - rsv_ptr) return NIL;
        start = rsv_ptr;
        for (int unsigned i = 0; i + 1 < count; i++) link_mem[start + i] = start + i + 1;
        link_mem[start + count - 1] = NIL;
        rsv_ptr += count;
        return start;
    endfunction

    // Sorted insert into the free list; a slab below the head becomes the head.
    function automatic void return_slab(int unsigned s);
        int unsigned cur, nxt, steps;
        steps = 0;
        if (s >= POOL) return;
        if (free_hd == NIL || s < free_hd) begin
            link_mem[s] = free_hd;
            free_hd = s;
            return;
        end
        if (s == free_hd) return;
        cur = free_hd;
        forever begin
            nxt = link_at(cur);
            if (nxt == s) return;
            if (nxt == NIL || nxt > s) break;
            cur = nxt;
            steps++;
            if (steps > POOL) return;
        end
        link_set(cur, s);
        link_mem[s] = nxt;
    endfunction

    function automatic void chain_append(int unsigned p, int unsigned start);
        int unsigned cur, steps;
        cur = chain_hd[p];
        steps = 0;
        if (cur == NIL) begin
            chain_hd[p] = start;
            return;
        end
        while (link_at(cur) != NIL && steps <= POOL) begin
            cur = link_at(cur);
            steps++;
        end
        link_set(cur, start);
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic lsa_pkg::t_lsa_rsp serve_request(lsa_pkg::t_lsa_req r);
        int unsigned       p, rem, cur, nxt, steps, tail, s, first;
        bit                ok;
        lsa_pkg::t_lsa_rsp res;
        p     = r.pid % PROCS;
        rem   = r.request_size;
        first = NIL;
        ok    = 1'b1;
        steps = 0;
        if (r.kind == lsa_pkg::KIND_FREE) begin
            cur = chain_hd[p];
            while (cur != NIL && steps <= POOL) begin
                nxt = link_at(cur);
                return_slab(cur);
                cur = nxt;
                steps++;
            end
            chain_hd[p] = NIL;
        end else if (rem != 0) begin
            if (free_hd == NIL) begin
                s = carve_reserve(round_to_blocks(rem));
                if (s == NIL) ok = 1'b0;
                else free_hd = s;
            end
            if (ok) begin
                tail = free_hd;
                while (link_at(tail) != NIL && rem > 1) begin
                    tail = link_at(tail);
                    rem--;
                end
                if (rem > 1) begin
                    s = carve_reserve(round_to_blocks(rem));
                    if (s == NIL) ok = 1'b0;
                    else begin
                        link_set(tail, s);
                        while (link_at(tail) != NIL && rem > 1) begin
                            tail = link_at(tail);
                            rem--;
                        end
                    end
                end
                if (ok) begin
                    first   = free_hd;
                    free_hd = link_at(tail);
                    link_set(tail, NIL);
                    chain_append(p, first);
                end
            end
        end
        res.status     = ok ? lsa_pkg::ST_OK : lsa_pkg::ST_OOM;
        res.first_slab = ok ? first[lsa_pkg::SIZE_W-1:0] : NIL[lsa_pkg::SIZE_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_row make_row(bit cfg_en, int cfg_val, logic kind, int pid,
                                      int size, bit typed, logic st, int first);
        t_row rw;
        rw.cfg_en               = cfg_en;
        rw.cfg_val              = cfg_val;
        rw.req.kind             = kind;
        rw.req.pid              = pid[lsa_pkg::PID_W-1:0];
        rw.req.request_size     = size[lsa_pkg::SIZE_W-1:0];
        rw.typed                = typed;
        rw.rsp.status           = st;
        rw.rsp.first_slab       = first[lsa_pkg::SIZE_W-1:0];
        return rw;
    endfunction

    // Wait until every expected beat is back, let the core settle, then write
    // the block size. The write enable is high for exactly one edge.
    task automatic retune(int value);
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[lsa_pkg::SIZE_W-1:0];
        blk_size  = value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one request beat and hold it until the core takes it. The model is
    // advanced at the accepting edge. Afterwards the sender either continues
    // the burst (valid stays high) or drops valid for a random gap.
    task automatic offer(lsa_pkg::t_lsa_req r, bit typed, lsa_pkg::t_lsa_rsp typed_rsp);
        lsa_pkg::t_lsa_rsp predicted;
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (in_stall);
        predicted = serve_request(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    function automatic lsa_pkg::t_lsa_req random_request();
        lsa_pkg::t_lsa_req r;
        int unsigned       pick;
        r.kind         = ($urandom_range(0, 99) < 35) ? lsa_pkg::KIND_FREE
                                                      : lsa_pkg::KIND_ALLOC;
        r.pid          = $urandom_range(0, PROCS - 1);
        pick           = $urandom_range(0, 199);
        // Mostly small requests keep the lists short; a few go to the extremes.
        if (pick < 20)       r.request_size = 0;
        else if (pick < 175) r.request_size = $urandom_range(1, 6);
        else if (pick < 197) r.request_size = $urandom_range(7, 40);
        else                 r.request_size = $urandom_range(1000, 1024);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: compare each accepted beat with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        lsa_pkg::t_lsa_rsp want;
        if (i_rst_n && out_valid && !out_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (pending_rsp.size() == 0) begin
                $error("unexpected result beat: status=%0d first_slab=%0d",
                       out_data.status, out_data.first_slab);
                fail_cnt++;
            end else begin
                want = pending_rsp.pop_front();
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_data.status);
                    fail_cnt++;
                end
                if (out_data.first_slab !== want.first_slab) begin
                    $error("first_slab: expected %0d, actual %0d",
                           want.first_slab, out_data.first_slab);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure. The pattern changes every so often between no
    // stalls, light stalls and heavy stalls. When a long hold-off is asked
    // for, the stall is held high for a fixed stretch so the core fills up
    // and pushes back on the request side while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin
        int unsigned mode;
        int unsigned left;
        int unsigned hold_left;
        bit          hold_done;
        mode      = 0;
        left      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 200);
            end else begin
                left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run with no beat accepted on either side for too long is
    // stuck. The limit sits well above the time it takes to free a full-pool
    // chain into a sorted list.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        lsa_pkg::t_lsa_rsp none;
        int                block_plan [4];
        none        = '0;
        block_plan  = '{1, 3, 16, 2};
        fail_cnt    = 0;
        idle_cycles = 0;
        rsp_seen    = 0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;

        // Model reset state. Link entries start at zero; they are only ever
        // read after being written.
        foreach (link_mem[i]) link_mem[i] = 0;
        foreach (chain_hd[i]) chain_hd[i] = NIL;
        free_hd  = NIL;
        rsv_ptr  = 0;
        blk_size = 1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. A zero block size behaves as one; the pool runs
        // out on a full-pool request with block size 1024; frees of empty
        // chains and zero-size allocates return the null slab.
        rows.push_back(make_row(1, 0,    lsa_pkg::KIND_ALLOC, 0,  0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  5,  0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 0,  1,    1, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 63, 3,    1, lsa_pkg::ST_OK,  1));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  0,  2047, 1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 1,  2,    0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  63, 0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  1,  0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(1, 1024, lsa_pkg::KIND_ALLOC, 2,  1024, 1, lsa_pkg::ST_OOM, NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 2,  1,    0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(1, 7,    lsa_pkg::KIND_ALLOC, 3,  1000, 0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 4,  1024, 0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 5,  5,    0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  3,  0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 42, 1024, 0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  2,  0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  4,  0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  5,  0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  42, 0,    1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(1, 1,    lsa_pkg::KIND_ALLOC, 21, 17,   0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_ALLOC, 42, 1024, 0, lsa_pkg::ST_OK,  0));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  21, 1024, 1, lsa_pkg::ST_OK,  NIL));
        rows.push_back(make_row(0, 0,    lsa_pkg::KIND_FREE,  42, 0,    1, lsa_pkg::ST_OK,  NIL));

        foreach (rows[i]) begin
            if (rows[i].cfg_en) retune(rows[i].cfg_val);
            offer(rows[i].req, rows[i].typed, rows[i].rsp);
        end

        // Random traffic, one block size per phase. The long receiver
        // hold-off is requested partway through the second phase.
        foreach (block_plan[ph]) begin
            retune(block_plan[ph]);
            for (int n = 0; n < 300; n++) begin
                if (ph == 1 && n == 50) hold_req = 1'b1;
                offer(random_request(), 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lsa_pkg.sv
sv/lsa_ram.sv
sv/lsa_round_unit.sv
sv/linked_slab_allocator_core.sv
bench/linked_slab_allocator_core_tb.sv
